// ===== src/lbvg_pkg.sv =====
// lbvg_pkg: types and constants for the lagrange basis value and gradient block
// no dependencies

package lbvg_pkg;

    localparam int CoordW = 16;
    localparam int ValW   = 18;
    localparam int IdxW   = 4;

    localparam logic [1:0] CFG_SHAPE  = 2'd0;
    localparam logic [1:0] CFG_DEGREE = 2'd1;

    typedef enum logic [1:0] {
        KIND_TRI1  = 2'd0,
        KIND_TRI2  = 2'd1,
        KIND_QUAD1 = 2'd2,
        KIND_QUAD2 = 2'd3
    } elem_kind_t;

    typedef struct packed {
        elem_kind_t         kind;
        logic signed [15:0] xi;
        logic signed [15:0] eta;
    } job_t;

    typedef struct packed {
        logic [3:0]         node_index;
        logic signed [17:0] basis_value;
        logic signed [17:0] grad_xi;
        logic signed [17:0] grad_eta;
        logic               last_node;
    } result_t;

    function automatic logic [3:0] node_count(elem_kind_t k);
        case (k)
            KIND_TRI1:  node_count = 4'd3;
            KIND_TRI2:  node_count = 4'd6;
            KIND_QUAD1: node_count = 4'd4;
            default:    node_count = 4'd9;
        endcase
    endfunction

endpackage

// ===== src/lbvg_if.sv =====
// lbvg_if: valid/ready channel carrying a packed payload
// no dependencies

interface lbvg_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/lbvg_front.sv =====
// lbvg_front: accepts points, holds the configuration, classifies the element
// depends on lbvg_pkg

module lbvg_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [1:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [31:0]       in_data,
    output logic              q_push,
    output lbvg_pkg::job_t    q_job,
    input  logic              q_full
);
    import lbvg_pkg::*;

    logic       shape_reg;
    logic [1:0] degree_reg;
    logic       degree_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg  <= 1'b0;
            degree_reg <= 2'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SHAPE)
                shape_reg <= cfg_wdata[0];
            else if (cfg_index == CFG_DEGREE)
                degree_reg <= cfg_wdata;
        end
    end

    // unsupported degree: item dropped here
    assign degree_ok = (degree_reg == 2'd1) || (degree_reg == 2'd2);
    assign in_ready  = !q_full;
    assign q_push    = in_valid && in_ready && degree_ok;

    always_comb
    begin
        q_job.kind = elem_kind_t'({shape_reg, degree_reg == 2'd2});
        q_job.xi   = in_data[31:16];
        q_job.eta  = in_data[15:0];
    end
endmodule

// ===== src/lbvg_queue.sv =====
// lbvg_queue: two-entry job queue between front and back
// depends on lbvg_pkg

module lbvg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lbvg_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output lbvg_pkg::job_t head
);
    import lbvg_pkg::*;

    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && !not_empty))
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
endmodule

// ===== src/lbvg_back.sv =====
// lbvg_back: evaluates one node per cycle while the output is not stalled, from precomputed products
// depends on lbvg_pkg

module lbvg_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  lbvg_pkg::job_t    q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output lbvg_pkg::result_t out_data
);
    import lbvg_pkg::*;

    localparam int PW = 36;
    localparam int MW = 24;
    localparam logic signed [PW-1:0] ONE = PW'(1) <<< FRAC_BITS;

    // stage 0: squares
    logic              s0_busy_reg, s1_busy_reg;
    elem_kind_t        s0_kind_reg, kind_reg;
    logic signed [PW-1:0] x0_reg, y0_reg, xx_reg, yy_reg, xy_reg;
    logic signed [PW-1:0] x_reg, y_reg, pxm_reg, pxp_reg, qx_reg, pym_reg, pyp_reg, qy_reg;
    logic [3:0]        node_reg;
    logic              ovalid_reg;
    result_t           odata_reg;
    logic              adv1, last1, s0_take, out_free;

    function automatic logic signed [PW-1:0] rnd(logic signed [2*PW-1:0] v, int s);
        logic signed [2*PW-1:0] q;
        q = v + ((2*PW)'(1) <<< (s - 1));
        rnd = PW'(q >>> s);
    endfunction

    // operands stay well inside MW bits for every node formula
    function automatic logic signed [PW-1:0] mulf(logic signed [PW-1:0] a,
                                                 logic signed [PW-1:0] b, int s);
        logic signed [MW-1:0]   an;
        logic signed [MW-1:0]   bn;
        logic signed [2*MW-1:0] p;
        an = a[MW-1:0];
        bn = b[MW-1:0];
        p = an * bn;
        mulf = rnd((2*PW)'(p), FRAC_BITS + s);
    endfunction

    function automatic logic signed [PW-1:0] rnd2(logic signed [PW-1:0] v);
        rnd2 = (v + PW'(2)) >>> 2;
    endfunction

    function automatic logic signed [17:0] sat(logic signed [PW-1:0] v);
        if (v > PW'(131071))
            sat = 18'sd131071;
        else if (v < -PW'(131072))
            sat = -18'sd131072;
        else
            sat = v[17:0];
    endfunction

    assign out_free = !ovalid_reg || out_ready;
    assign last1    = node_reg == node_count(kind_reg) - 4'd1;
    assign adv1     = s1_busy_reg && out_free;
    assign s0_take  = q_valid && (!s0_busy_reg || (!s1_busy_reg || (adv1 && last1)));
    assign q_pop    = s0_take;

    logic s0_move;
    assign s0_move = s0_busy_reg && (!s1_busy_reg || (adv1 && last1));

    always_ff @(posedge clk)
    begin
        if (s0_take && !(s0_busy_reg && !s0_move))
        begin
            s0_kind_reg <= q_head.kind;
            x0_reg      <= PW'(q_head.xi);
            y0_reg      <= PW'(q_head.eta);
            xx_reg      <= mulf(PW'(q_head.xi), PW'(q_head.xi), 0);
            yy_reg      <= mulf(PW'(q_head.eta), PW'(q_head.eta), 0);
            xy_reg      <= mulf(PW'(q_head.xi), PW'(q_head.eta), 0);
        end
        if (s0_move)
        begin
            kind_reg <= s0_kind_reg;
            x_reg    <= x0_reg;
            y_reg    <= y0_reg;
            pxm_reg  <= xx_reg - x0_reg;
            pxp_reg  <= xx_reg + x0_reg;
            qx_reg   <= ONE - xx_reg;
            pym_reg  <= yy_reg - y0_reg;
            pyp_reg  <= yy_reg + y0_reg;
            qy_reg   <= ONE - yy_reg;
            // triangle quadratic reuses pxm as xy
            if (s0_kind_reg == KIND_TRI2)
                pxm_reg <= xy_reg;
        end
    end

    logic s0_fill;
    assign s0_fill = s0_take && !(s0_busy_reg && !s0_move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_busy_reg <= 1'b0;
            s1_busy_reg <= 1'b0;
            node_reg    <= 4'd0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            s0_busy_reg <= s0_fill || (s0_busy_reg && !s0_move);
            if (s0_move)
            begin
                s1_busy_reg <= 1'b1;
                node_reg    <= 4'd0;
            end
            else if (adv1)
            begin
                s1_busy_reg <= !last1;
                node_reg    <= node_reg + 4'd1;
            end
            if (adv1)
                ovalid_reg <= 1'b1;
            else if (out_ready)
                ovalid_reg <= 1'b0;
        end
    end

    // per-node selection: at most one multiply for each output
    logic signed [PW-1:0] va, vb, ga, gb, ha, hb, v, gx, gy, xx1, yy1, xy1;
    int vs, gs, hs;
    logic vm, gm, hm;

    always_comb
    begin
        va = '0; vb = '0; ga = '0; gb = '0; ha = '0; hb = '0;
        vs = 0; gs = 0; hs = 0; vm = 1'b0; gm = 1'b0; hm = 1'b0;
        v = '0; gx = '0; gy = '0;
        xx1 = qx_reg; xy1 = pxm_reg; yy1 = qy_reg;
        xx1 = ONE - qx_reg; yy1 = ONE - qy_reg;
        case (kind_reg)
            KIND_TRI1:
                case (node_reg)
                    4'd0: begin v = ONE - x_reg - y_reg; gx = -ONE; gy = -ONE; end
                    4'd1: begin v = x_reg; gx = ONE; end
                    default: begin v = y_reg; gy = ONE; end
                endcase
            KIND_TRI2:
                case (node_reg)
                    4'd0:
                    begin
                        v  = ONE - 3*x_reg - 3*y_reg + 2*xx1 + 2*yy1 + 4*xy1;
                        gx = -3*ONE + 4*x_reg + 4*y_reg; gy = gx;
                    end
                    4'd1: begin v = 2*xx1 - x_reg; gx = 4*x_reg - ONE; end
                    4'd2: begin v = 2*yy1 - y_reg; gy = 4*y_reg - ONE; end
                    4'd3:
                    begin
                        v = 4*(x_reg - xx1 - xy1); gx = 4*(ONE - 2*x_reg - y_reg);
                        gy = -4*x_reg;
                    end
                    4'd4: begin v = 4*xy1; gx = 4*y_reg; gy = 4*x_reg; end
                    default:
                    begin
                        v = 4*(y_reg - yy1 - xy1); gx = -4*y_reg;
                        gy = 4*(ONE - 2*y_reg - x_reg);
                    end
                endcase
            KIND_QUAD1:
            begin
                vm = 1'b1; vs = 2;
                case (node_reg)
                    4'd0: begin va = ONE - x_reg; vb = ONE - y_reg;
                        gx = rnd2(y_reg - ONE); gy = rnd2(x_reg - ONE); end
                    4'd1: begin va = ONE + x_reg; vb = ONE - y_reg;
                        gx = rnd2(ONE - y_reg); gy = rnd2(-ONE - x_reg); end
                    4'd2: begin va = ONE + x_reg; vb = ONE + y_reg;
                        gx = rnd2(ONE + y_reg); gy = rnd2(ONE + x_reg); end
                    default: begin va = ONE - x_reg; vb = ONE + y_reg;
                        gx = rnd2(-ONE - y_reg); gy = rnd2(ONE - x_reg); end
                endcase
            end
            default:
            begin
                vm = 1'b1; gm = 1'b1; hm = 1'b1;
                case (node_reg)
                    4'd0: begin va = pxm_reg; vb = pym_reg; vs = 2;
                        ga = 2*x_reg - ONE; gb = pym_reg; gs = 2;
                        ha = pxm_reg; hb = 2*y_reg - ONE; hs = 2; end
                    4'd1: begin va = pxp_reg; vb = pym_reg; vs = 2;
                        ga = 2*x_reg + ONE; gb = pym_reg; gs = 2;
                        ha = pxp_reg; hb = 2*y_reg - ONE; hs = 2; end
                    4'd2: begin va = pxp_reg; vb = pyp_reg; vs = 2;
                        ga = 2*x_reg + ONE; gb = pyp_reg; gs = 2;
                        ha = pxp_reg; hb = 2*y_reg + ONE; hs = 2; end
                    4'd3: begin va = pxm_reg; vb = pyp_reg; vs = 2;
                        ga = 2*x_reg - ONE; gb = pyp_reg; gs = 2;
                        ha = pxm_reg; hb = 2*y_reg + ONE; hs = 2; end
                    4'd4: begin va = qx_reg; vb = pym_reg; vs = 1;
                        ga = -x_reg; gb = pym_reg; gs = 0;
                        ha = qx_reg; hb = 2*y_reg - ONE; hs = 1; end
                    4'd5: begin va = pxp_reg; vb = qy_reg; vs = 1;
                        ga = 2*x_reg + ONE; gb = qy_reg; gs = 1;
                        ha = -pxp_reg; hb = y_reg; hs = 0; end
                    4'd6: begin va = qx_reg; vb = pyp_reg; vs = 1;
                        ga = -x_reg; gb = pyp_reg; gs = 0;
                        ha = qx_reg; hb = 2*y_reg + ONE; hs = 1; end
                    4'd7: begin va = pxm_reg; vb = qy_reg; vs = 1;
                        ga = 2*x_reg - ONE; gb = qy_reg; gs = 1;
                        ha = pxm_reg; hb = -y_reg; hs = 0; end
                    default: begin va = qx_reg; vb = qy_reg; vs = 0;
                        ga = -2*x_reg; gb = qy_reg; gs = 0;
                        ha = -2*y_reg; hb = qx_reg; hs = 0; end
                endcase
            end
        endcase
        if (vm)
            v = mulf(va, vb, vs);
        if (gm)
            gx = mulf(ga, gb, gs);
        if (hm)
            gy = mulf(ha, hb, hs);
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            odata_reg.node_index  <= node_reg;
            odata_reg.basis_value <= sat(v);
            odata_reg.grad_xi     <= sat(gx);
            odata_reg.grad_eta    <= sat(gy);
            odata_reg.last_node   <= last1;
        end
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    assert property (@(posedge clk) disable iff (!rst_n) adv1 |-> node_reg < 4'd9)
        else $error("node index past nine");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !out_ready) |=> $stable(odata_reg))
        else $error("held result changed");
    assert property (@(posedge clk) disable iff (!rst_n) s0_move |-> !s1_busy_reg || last1)
        else $error("point overtakes node walk");
endmodule

// ===== src/lagrange_basis_values_and_grads.sv =====
// lagrange_basis_values_and_grads: top level of the basis value and gradient block
// depends on lbvg_pkg, lbvg_if, lbvg_front, lbvg_queue, lbvg_back
//
// in: one item per point, data = {ref_xi, ref_eta}, accepted on valid && ready
// out: one item per node, data = {node_index, basis_value, grad_xi, grad_eta,
//      last_node}; 3, 6, 4 or 9 items per point, last_node on the final one
// config: cfg_we, cfg_index, cfg_wdata; index 0 element shape, 1 degree;
//         write only while idle; unsupported degree drops the point
// path: a taken point passes the queue, the squaring stage and the node stage into the output register
// throughput: one node item per cycle while the receiver is ready; the node walk
//             in the back end sets this
// a two-entry queue and a squaring stage let points be taken while
// nodes of the previous point still go out
// reset clears the queue and the output valid, shape to triangle,
// degree to linear
// a stalled receiver holds the output item; the back end then stops,
// the queue fills and in.ready falls

module lagrange_basis_values_and_grads #(
    parameter int FRAC_BITS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_wdata,
    lbvg_if.sink        in_ch,
    lbvg_if.source      out_ch
);
    import lbvg_pkg::*;

    logic    push, full, pop, nonempty;
    job_t    push_job, head;
    result_t res;

    lbvg_front u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data[31:0]),
        .q_push(push), .q_job(push_job), .q_full(full)
    );

    lbvg_queue u_queue (
        .clk, .rst_n, .push, .push_job, .full, .pop, .not_empty(nonempty), .head
    );

    lbvg_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .q_valid(nonempty), .q_head(head), .q_pop(pop),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(res)
    );

    assign out_ch.data = res;
endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for lagrange_basis_values_and_grads
// drives points through lbvg_if channels and predicts every node item
// depends on lbvg_pkg, lbvg_if and the block's rtl
`timescale 1ns / 1ps

module tb_top;
    import lbvg_pkg::*;

    localparam int FRAC = 14;
    localparam longint ONE = 64'sd1 <<< FRAC;
    localparam int HALF_PERIOD = 10;

    typedef struct {
        bit          shape;
        logic [1:0]  degree;
        logic [15:0] xi;
        logic [15:0] eta;
        bit          has_v0;
        int          v0;
    } point_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [1:0] cfg_wdata = '0;

    lbvg_if #(.W(32)) in_if ();
    lbvg_if #(.W($bits(result_t))) out_if ();

    lagrange_basis_values_and_grads dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    always #HALF_PERIOD clk = ~clk;

    bit         cur_shape;
    logic [1:0] cur_degree;
    result_t    node_q[$];
    int         errors = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;

    function automatic longint round_sh(longint v, int s);
        if (s == 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint fmul(longint a, longint b, int s);
        return round_sh(a * b, FRAC + s);
    endfunction

    function automatic logic signed [17:0] sat18(longint v);
        if (v > 131071)
            v = 131071;
        if (v < -131072)
            v = -131072;
        return v[17:0];
    endfunction

    // push the node items expected for one point
    task automatic predict_nodes(logic [15:0] rxi, logic [15:0] reta);
        longint x, y, xx, yy, xy, pxm, pxp, qx, pym, pyp, qy, xm, xp, ym, yp;
        longint a, b, c, d;
        longint v[9], gx[9], gy[9];
        int n;
        result_t r;
        x = longint'($signed(rxi));
        y = longint'($signed(reta));
        n = 0;
        if (cur_degree != 2'd1 && cur_degree != 2'd2)
            return;
        xx = fmul(x, x, 0);
        yy = fmul(y, y, 0);
        xy = fmul(x, y, 0);
        if (!cur_shape && cur_degree == 2'd1)
        begin
            v[0] = ONE - x - y; gx[0] = -ONE; gy[0] = -ONE;
            v[1] = x;           gx[1] = ONE;  gy[1] = 0;
            v[2] = y;           gx[2] = 0;    gy[2] = ONE;
            n = 3;
        end
        else if (!cur_shape)
        begin
            v[0] = ONE - 3 * x - 3 * y + 2 * xx + 2 * yy + 4 * xy;
            v[1] = 2 * xx - x;
            v[2] = 2 * yy - y;
            v[3] = 4 * (x - xx - xy);
            v[4] = 4 * xy;
            v[5] = 4 * (y - yy - xy);
            gx[0] = -3 * ONE + 4 * x + 4 * y; gy[0] = gx[0];
            gx[1] = 4 * x - ONE;              gy[1] = 0;
            gx[2] = 0;                        gy[2] = 4 * y - ONE;
            gx[3] = 4 * (ONE - 2 * x - y);    gy[3] = -4 * x;
            gx[4] = 4 * y;                    gy[4] = 4 * x;
            gx[5] = -4 * y;                   gy[5] = 4 * (ONE - 2 * y - x);
            n = 6;
        end
        else if (cur_degree == 2'd1)
        begin
            a = ONE - x; b = ONE + x; c = ONE - y; d = ONE + y;
            v[0] = fmul(a, c, 2); gx[0] = round_sh(y - ONE, 2); gy[0] = round_sh(x - ONE, 2);
            v[1] = fmul(b, c, 2); gx[1] = round_sh(c, 2);       gy[1] = round_sh(-b, 2);
            v[2] = fmul(b, d, 2); gx[2] = round_sh(d, 2);       gy[2] = round_sh(b, 2);
            v[3] = fmul(a, d, 2); gx[3] = round_sh(-d, 2);      gy[3] = round_sh(a, 2);
            n = 4;
        end
        else
        begin
            pxm = xx - x; pxp = xx + x; qx = ONE - xx;
            pym = yy - y; pyp = yy + y; qy = ONE - yy;
            xm = 2 * x - ONE; xp = 2 * x + ONE;
            ym = 2 * y - ONE; yp = 2 * y + ONE;
            v[0] = fmul(pxm, pym, 2); gx[0] = fmul(xm, pym, 2); gy[0] = fmul(pxm, ym, 2);
            v[1] = fmul(pxp, pym, 2); gx[1] = fmul(xp, pym, 2); gy[1] = fmul(pxp, ym, 2);
            v[2] = fmul(pxp, pyp, 2); gx[2] = fmul(xp, pyp, 2); gy[2] = fmul(pxp, yp, 2);
            v[3] = fmul(pxm, pyp, 2); gx[3] = fmul(xm, pyp, 2); gy[3] = fmul(pxm, yp, 2);
            v[4] = fmul(qx, pym, 1);  gx[4] = fmul(-x, pym, 0); gy[4] = fmul(qx, ym, 1);
            v[5] = fmul(pxp, qy, 1);  gx[5] = fmul(xp, qy, 1);  gy[5] = fmul(-pxp, y, 0);
            v[6] = fmul(qx, pyp, 1);  gx[6] = fmul(-x, pyp, 0); gy[6] = fmul(qx, yp, 1);
            v[7] = fmul(pxm, qy, 1);  gx[7] = fmul(xm, qy, 1);  gy[7] = fmul(pxm, -y, 0);
            v[8] = fmul(qx, qy, 0);   gx[8] = fmul(-2 * x, qy, 0); gy[8] = fmul(-2 * y, qx, 0);
            n = 9;
        end
        for (int k = 0; k < n; k++)
        begin
            r.node_index  = k[3:0];
            r.basis_value = sat18(v[k]);
            r.grad_xi     = sat18(gx[k]);
            r.grad_eta    = sat18(gy[k]);
            r.last_node   = (k == n - 1);
            node_q.push_back(r);
        end
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (node_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SHAPE)
            cur_shape = val[0];
        else if (idx == CFG_DEGREE)
            cur_degree = val;
    endtask

    task automatic set_mode(bit shape, logic [1:0] degree);
        wait_drain();
        write_reg(CFG_SHAPE, {1'b0, shape});
        write_reg(CFG_DEGREE, degree);
    endtask

    task automatic send_point(logic [15:0] rxi, logic [15:0] reta);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= {rxi, reta};
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_nodes(rxi, reta);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'sd16384;
            2:       return -16'sd16384;
            default: return 16'($signed($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        out_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_if.ready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (quiet || $urandom_range(0, 2) != 0)
            begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // check each node item against the oldest expectation
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            got = out_if.data;
            if (node_q.size() == 0)
            begin
                $error("unexpected node item %p", got);
                errors++;
            end
            else
            begin
                want = node_q.pop_front();
                if (got.node_index !== want.node_index)
                begin
                    $error("node_index exp %0d got %0d", want.node_index, got.node_index);
                    errors++;
                end
                if (got.basis_value !== want.basis_value)
                begin
                    $error("basis_value exp %0d got %0d", want.basis_value, got.basis_value);
                    errors++;
                end
                if (got.grad_xi !== want.grad_xi)
                begin
                    $error("grad_xi exp %0d got %0d", want.grad_xi, got.grad_xi);
                    errors++;
                end
                if (got.grad_eta !== want.grad_eta)
                begin
                    $error("grad_eta exp %0d got %0d", want.grad_eta, got.grad_eta);
                    errors++;
                end
                if (got.last_node !== want.last_node)
                begin
                    $error("last_node exp %0d got %0d", want.last_node, got.last_node);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        point_row_t rows[$];
        bit shapes[6];
        logic [1:0] degrees[6];
        int n_items;
        rows = '{
            '{0, 2'd1, 16'h0000, 16'h0000, 1, 16384},
            '{0, 2'd1, 16'h4000, 16'h0000, 1, 0},
            '{0, 2'd1, 16'h8000, 16'h8000, 1, 81920},
            '{0, 2'd1, 16'h7fff, 16'h7fff, 1, -49150},
            '{0, 2'd2, 16'h0000, 16'h0000, 1, 16384},
            '{0, 2'd2, 16'h2000, 16'h2000, 0, 0},
            '{0, 2'd2, 16'h8000, 16'h7fff, 0, 0},
            '{0, 2'd2, 16'hc000, 16'h4000, 0, 0},
            '{1, 2'd1, 16'h0000, 16'h0000, 1, 4096},
            '{1, 2'd1, 16'hc000, 16'hc000, 1, 16384},
            '{1, 2'd1, 16'h4000, 16'h4000, 1, 0},
            '{1, 2'd1, 16'h8000, 16'h8000, 0, 0},
            '{1, 2'd2, 16'h0000, 16'h0000, 1, 0},
            '{1, 2'd2, 16'hc000, 16'hc000, 1, 16384},
            '{1, 2'd2, 16'h4000, 16'hc000, 0, 0},
            '{1, 2'd2, 16'h7fff, 16'h8000, 0, 0},
            '{1, 2'd2, 16'h1234, 16'hedcb, 0, 0},
            '{1, 2'd0, 16'h1000, 16'h1000, 0, 0},
            '{0, 2'd3, 16'h1000, 16'h1000, 0, 0}
        };
        shapes  = '{0, 0, 1, 1, 1, 0};
        degrees = '{2'd1, 2'd2, 2'd1, 2'd2, 2'd0, 2'd2};
        cur_shape  = 1'b0;
        cur_degree = 2'd1;
        in_if.valid = 1'b0;
        in_if.data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].shape != cur_shape || rows[i].degree != cur_degree)
                set_mode(rows[i].shape, rows[i].degree);
            send_point(rows[i].xi, rows[i].eta);
            if (rows[i].has_v0 && node_q[$].node_index != 0 &&
                node_q[node_q.size() - 1 - node_q[$].node_index].basis_value
                    !== 18'(rows[i].v0))
            begin
                $error("basis_value exp %0d got %0d", rows[i].v0,
                       node_q[node_q.size() - 1 - node_q[$].node_index].basis_value);
                errors++;
            end
        end

        // writes outside the register list are dropped and only bit 0 of shape data is kept
        wait_drain();
        write_reg(2'd2, 2'd3);
        write_reg(2'd3, 2'd0);
        write_reg(CFG_SHAPE, 2'd2);
        write_reg(CFG_DEGREE, 2'd2);
        send_point(16'h1000, 16'h0800);

        foreach (shapes[p])
        begin
            set_mode(shapes[p], degrees[p]);
            n_items = (degrees[p] == 2'd0) ? 8 : 34;
            if (p == 5)
                quiet = 1'b1;
            for (int i = 0; i < n_items; i++)
            begin
                if (p == 1 && i == 5)
                    hold_req = 1'b1;
                if (p == 1 && i > 5 && i < 12)
                begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= {rand_coord(), rand_coord()};
                    @(posedge clk);
                    while (!in_if.ready)
                        @(posedge clk);
                    predict_nodes(in_if.data[31:16], in_if.data[15:0]);
                end
                else
                    send_point(rand_coord(), rand_coord());
            end
        end

        wait_drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== sim.f =====
src/lbvg_pkg.sv
src/lbvg_if.sv
src/lbvg_front.sv
src/lbvg_queue.sv
src/lbvg_back.sv
src/lagrange_basis_values_and_grads.sv
tb/tb_top.sv
